/* design/isfu_pkg.sv */
// ----------------------------------------------------------------------------
// isfu_pkg: shared types and constants of the Ising spin-flip unit
// Widths of the fixed-point datapath, register indexes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package isfu_pkg;

    localparam int W_FIX  = 32;              // Q16.16 fields
    localparam int W_BETA = 31;              // inverse temperature register
    localparam int W_ACC  = 48;              // row accumulator
    localparam int W_EV   = 51;              // 2*(sum + tunnel) + field
    localparam int W_M    = 53;              // conditioned energy, multiplicand
    localparam int W_D    = 32;              // 2*beta, multiplier
    localparam int W_P    = W_M + W_D;       // product
    localparam int W_CNT  = $clog2(W_D);
    localparam int W_ADDR = 2;

    localparam logic [W_ADDR-1:0] REG_BETA  = 2'd0;
    localparam logic [W_ADDR-1:0] REG_JPERP = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PREP,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;        // a beat is taken on the input channel
        logic out_load_act;  // inactive row: pass spin through
        logic eval_en;       // form the energy
        logic prep_en;       // condition energy, start multiplier
        logic mul_step;      // one shift-add step
        logic out_load_mul;  // compare product and load result
    } cmd_t;

    typedef struct packed {
        logic mul_last;      // final multiplier step in progress
    } status_t;

endpackage

/* design/isfu_ctrl.sv */
// ----------------------------------------------------------------------------
// isfu_ctrl: controller of the Ising spin-flip unit
// Sequences accumulate, evaluate, multiply and compare, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module isfu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_row_last,
    input  logic             s_active,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output isfu_pkg::cmd_t    cmd,
    input  isfu_pkg::status_t status
);

    isfu_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign s_ready = (state_reg == isfu_pkg::ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            isfu_pkg::ST_IDLE: begin
                if (accept && s_row_last && s_active) state_next = isfu_pkg::ST_EVAL;
            end
            isfu_pkg::ST_EVAL: state_next = isfu_pkg::ST_PREP;
            isfu_pkg::ST_PREP: state_next = isfu_pkg::ST_MUL;
            isfu_pkg::ST_MUL: begin
                if (status.mul_last) state_next = isfu_pkg::ST_DONE;
            end
            isfu_pkg::ST_DONE: state_next = isfu_pkg::ST_IDLE;
            default: state_next = isfu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            isfu_pkg::ST_IDLE: begin
                cmd.accept       = accept;
                cmd.out_load_act = accept && s_row_last && !s_active;
            end
            isfu_pkg::ST_EVAL: cmd.eval_en      = 1'b1;
            isfu_pkg::ST_PREP: cmd.prep_en      = 1'b1;
            isfu_pkg::ST_MUL:  cmd.mul_step     = 1'b1;
            isfu_pkg::ST_DONE: cmd.out_load_mul = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) out_valid_next = 1'b0;
        if (cmd.out_load_act || cmd.out_load_mul) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= isfu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/isfu_datapath.sv */
// ----------------------------------------------------------------------------
// isfu_datapath: datapath of the Ising spin-flip unit
// Row accumulator, energy evaluation, shift-add multiplier and the final
// threshold compare, plus the two configuration registers.
// ----------------------------------------------------------------------------
module isfu_datapath #(
    parameter int TROTTER_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [isfu_pkg::W_ADDR-1:0]         cfg_addr,
    input  logic [isfu_pkg::W_FIX-1:0]          cfg_wdata,
    input  logic                                s_neighbour_spin,
    input  logic signed [isfu_pkg::W_FIX-1:0]   s_coupling,
    input  logic                                s_row_last,
    input  logic                                s_target_spin,
    input  logic                                s_up_spin,
    input  logic                                s_down_spin,
    input  logic signed [isfu_pkg::W_FIX-1:0]   s_local_field,
    input  logic signed [isfu_pkg::W_FIX-1:0]   s_log_random,
    output logic                                m_new_spin,
    output logic                                m_flipped,
    input  isfu_pkg::cmd_t                      cmd,
    output isfu_pkg::status_t                   status
);

    localparam int TUN_W = isfu_pkg::W_FIX + $clog2(TROTTER_COUNT) + 1;
    localparam logic signed [isfu_pkg::W_ACC:0] ACC_MAX = (isfu_pkg::W_ACC+1)'((64'sd1 <<< (isfu_pkg::W_ACC-1)) - 64'sd1);
    localparam logic signed [isfu_pkg::W_ACC:0] ACC_MIN = -ACC_MAX - (isfu_pkg::W_ACC+1)'(1);

    logic [isfu_pkg::W_BETA-1:0]        beta_reg;
    logic signed [isfu_pkg::W_FIX-1:0]  jperp_reg;
    logic signed [isfu_pkg::W_ACC-1:0]  acc_reg, sum_reg;
    logic                               tspin_reg, up_reg, down_reg;
    logic signed [isfu_pkg::W_FIX-1:0]  field_reg, lrand_reg;
    logic signed [isfu_pkg::W_EV-1:0]   ev_reg;
    logic signed [isfu_pkg::W_M-1:0]    mcand_reg;
    logic [isfu_pkg::W_D-1:0]           mplier_reg;
    logic signed [isfu_pkg::W_P-1:0]    prod_reg;
    logic [isfu_pkg::W_CNT-1:0]         cnt_reg;
    logic                               new_spin_reg, flipped_reg;

    logic signed [isfu_pkg::W_ACC:0]    addend, sum_wide, sum_sat_w;
    logic signed [isfu_pkg::W_ACC-1:0]  sum_sat;
    logic signed [TUN_W-1:0]            jp_ext, tun;
    logic signed [isfu_pkg::W_EV-1:0]   tun_ev, base, ev_next;
    logic signed [isfu_pkg::W_M-1:0]    ev_m, mcand_next;
    logic                               thr_neg;
    logic [isfu_pkg::W_D-1:0]           d_next;
    logic signed [isfu_pkg::W_P-1:0]    prod_next, thr_p;
    logic                               flip;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg  <= isfu_pkg::W_BETA'(65536);
            jperp_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                isfu_pkg::REG_BETA:  beta_reg  <= cfg_wdata[isfu_pkg::W_BETA-1:0];
                isfu_pkg::REG_JPERP: jperp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturating row accumulator.
    always_comb begin
        addend    = s_neighbour_spin ? (isfu_pkg::W_ACC+1)'(s_coupling)
                                     : -(isfu_pkg::W_ACC+1)'(s_coupling);
        sum_wide  = (isfu_pkg::W_ACC+1)'(acc_reg) + addend;
        sum_sat_w = sum_wide;
        if (sum_wide > ACC_MAX) sum_sat_w = ACC_MAX;
        if (sum_wide < ACC_MIN) sum_sat_w = ACC_MIN;
        sum_sat   = sum_sat_w[isfu_pkg::W_ACC-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.accept) begin
            acc_reg <= s_row_last ? '0 : sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_row_last) begin
            sum_reg   <= sum_sat;
            tspin_reg <= s_target_spin;
            up_reg    <= s_up_spin;
            down_reg  <= s_down_spin;
            field_reg <= s_local_field;
            lrand_reg <= s_log_random;
        end
    end

    // Energy: 2*(sum +/- tunnel term) + field.
    always_comb begin
        jp_ext  = TUN_W'(jperp_reg);
        tun     = jp_ext * TUN_W'(TROTTER_COUNT);
        tun_ev  = isfu_pkg::W_EV'(tun);
        base    = isfu_pkg::W_EV'(sum_reg);
        if (up_reg == down_reg) base = up_reg ? base - tun_ev : base + tun_ev;
        ev_next = (base <<< 1) + isfu_pkg::W_EV'(field_reg);
    end

    // The test e > trunc(N/D) with D > 0 becomes e*D > N for N >= 0 and
    // (e-1)*D >= N for N < 0; the sign flip for a down target is folded in.
    always_comb begin
        thr_neg    = lrand_reg[isfu_pkg::W_FIX-1];
        ev_m       = isfu_pkg::W_M'(ev_reg);
        mcand_next = tspin_reg ? ev_m - isfu_pkg::W_M'(thr_neg)
                               : ~ev_m + isfu_pkg::W_M'(!thr_neg);
        d_next     = (beta_reg == '0) ? isfu_pkg::W_D'(2) : {beta_reg, 1'b0};
        prod_next  = (prod_reg <<< 1)
                   + (mplier_reg[isfu_pkg::W_D-1] ? isfu_pkg::W_P'(mcand_reg) : '0);
        thr_p      = {{(isfu_pkg::W_P-isfu_pkg::W_FIX-16){lrand_reg[isfu_pkg::W_FIX-1]}},
                      lrand_reg, 16'b0};
        flip       = thr_neg ? (prod_reg >= thr_p) : (prod_reg > thr_p);
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval_en) ev_reg <= ev_next;
        if (cmd.prep_en) begin
            mcand_reg  <= mcand_next;
            mplier_reg <= d_next;
            prod_reg   <= '0;
            cnt_reg    <= '0;
        end else if (cmd.mul_step) begin
            mplier_reg <= mplier_reg << 1;
            prod_reg   <= prod_next;
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    assign status.mul_last = (cnt_reg == '1);

    always_ff @(posedge aclk) begin
        if (cmd.out_load_act) begin
            new_spin_reg <= s_target_spin;
            flipped_reg  <= 1'b0;
        end else if (cmd.out_load_mul) begin
            new_spin_reg <= tspin_reg ^ flip;
            flipped_reg  <= flip;
        end
    end

    assign m_new_spin = new_spin_reg;
    assign m_flipped  = flipped_reg;

endmodule

/* design/ising_spin_flip_unit.sv */
// ----------------------------------------------------------------------------
// ising_spin_flip_unit: Metropolis spin-flip decision over a coupling row
// Accumulates signed couplings of one row and decides on the last beat
// whether the target spin flips.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_*) takes one beat per coupling of a row. A beat
// without s_row_last is absorbed and gives no result. The beat
// with s_row_last also carries the target spin, the spins of the adjacent
// trotter slices, the local field, the log-random value and s_active, and
// gives exactly one result beat on the m_* channel.
// Coupling beats stream at one per cycle unless a stalled result holds s_ready
// low. An inactive last beat puts its result on the output in the next
// cycle. An active last beat forms the energy, conditions it, multiplies it
// bit-serially by twice beta in the datapath, and compares the product
// against the scaled log-random value. No input is taken until this
// decision is done.
// The result sits in an output register; the next row's beats are taken
// while it waits, unless the receiver stalls, in which case s_ready stays
// low until m_ready takes the result.
// Reset clears the accumulator, the output valid flag and sets beta to 1.0
// and the transverse coupling to 0. Configuration writes take effect at once
// and belong between rows while the unit is idle.
// ----------------------------------------------------------------------------
module ising_spin_flip_unit #(
    parameter int TROTTER_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [isfu_pkg::W_ADDR-1:0]         cfg_addr,
    input  logic [isfu_pkg::W_FIX-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_neighbour_spin,
    input  logic signed [isfu_pkg::W_FIX-1:0]   s_coupling,
    input  logic                                s_row_last,
    input  logic                                s_active,
    input  logic                                s_target_spin,
    input  logic                                s_up_spin,
    input  logic                                s_down_spin,
    input  logic signed [isfu_pkg::W_FIX-1:0]   s_local_field,
    input  logic signed [isfu_pkg::W_FIX-1:0]   s_log_random,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_new_spin,
    output logic                                m_flipped
);

    // Commands go from the controller to the datapath; the datapath reports
    // back when the multiplier reaches its final step.
    isfu_pkg::cmd_t    cmd;
    isfu_pkg::status_t status;

    isfu_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_row_last (s_row_last),
        .s_active   (s_active),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .status     (status)
    );

    isfu_datapath #(
        .TROTTER_COUNT (TROTTER_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_neighbour_spin (s_neighbour_spin),
        .s_coupling       (s_coupling),
        .s_row_last       (s_row_last),
        .s_target_spin    (s_target_spin),
        .s_up_spin        (s_up_spin),
        .s_down_spin      (s_down_spin),
        .s_local_field    (s_local_field),
        .s_log_random     (s_log_random),
        .m_new_spin       (m_new_spin),
        .m_flipped        (m_flipped),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

/* design/isfu_checker.sv */
// ----------------------------------------------------------------------------
// isfu_checker: port-level assertions of the Ising spin-flip unit
// Watches both channels and checks result timing and pass-through rules.
// ----------------------------------------------------------------------------
module isfu_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_row_last,
    input logic s_active,
    input logic s_target_spin,
    input logic m_valid,
    input logic m_ready,
    input logic m_new_spin,
    input logic m_flipped
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_spin) && $stable(m_flipped))
        else $error("result beat changed while stalled");

    // An inactive row passes its spin straight through on the next cycle.
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_row_last && !s_active |=>
        m_valid && !m_flipped && (m_new_spin == $past(s_target_spin)))
        else $error("inactive row did not pass spin through");

    // A coupling beat that is not last produces no result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_row_last && (!m_valid || m_ready) |=> !m_valid)
        else $error("result without a last beat");

    // An active decision keeps the input closed while it runs.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_row_last && s_active |=> !s_ready ##1 !s_ready)
        else $error("input taken during decision");

endmodule

bind ising_spin_flip_unit isfu_checker u_isfu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_row_last    (s_row_last),
    .s_active      (s_active),
    .s_target_spin (s_target_spin),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_new_spin    (m_new_spin),
    .m_flipped     (m_flipped)
);

/* bench/ising_spin_flip_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ising_spin_flip_unit_test: self-checking bench of the spin-flip unit
// Streams coupling rows through the unit under several beta and jperp
// settings, predicts each Metropolis decision in the bench and compares
// every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module ising_spin_flip_unit_test;

    localparam int TROTTER = 4;
    localparam int N_RAND_ROWS = 110;
    localparam longint CYCLE_LIMIT = 600000;
    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    // One input beat as the driver presents it.
    typedef struct packed {
        logic        nspin;
        logic [31:0] coupling;
        logic        last;
        logic        active;
        logic        tspin;
        logic        up;
        logic        down;
        logic [31:0] field;
        logic [31:0] logr;
    } beat_t;

    typedef struct packed {
        logic new_spin;
        logic flipped;
    } decision_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [isfu_pkg::W_ADDR-1:0] cfg_addr = isfu_pkg::REG_BETA;
    logic [isfu_pkg::W_FIX-1:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    beat_t       s_beat = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_new_spin;
    logic        m_flipped;

    ising_spin_flip_unit #(.TROTTER_COUNT(TROTTER)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_neighbour_spin(s_beat.nspin), .s_coupling(s_beat.coupling),
        .s_row_last(s_beat.last), .s_active(s_beat.active),
        .s_target_spin(s_beat.tspin), .s_up_spin(s_beat.up),
        .s_down_spin(s_beat.down), .s_local_field(s_beat.field),
        .s_log_random(s_beat.logr),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_spin(m_new_spin), .m_flipped(m_flipped)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Bench copy of the unit's registers and row accumulator.
    logic [30:0] beta_q;
    longint      jperp_q;
    longint      row_energy;

    beat_t       pending_beats[$];
    decision_t   expected_decisions[$];
    int          error_count = 0;
    longint      cycle_count = 0;

    // The stimulus process raises these to steer the two channel processes.
    bit          sender_hold = 1'b0;
    bit          long_stall_req = 1'b0;

    // Apply one beat to the accumulator and, on the last beat of a row,
    // queue the Metropolis decision that the unit must return.
    function automatic void predict_beat(beat_t b);
        longint j, e, tun, beta, thr;
        bit flip;
        j = longint'($signed(b.coupling));
        row_energy = row_energy + (b.nspin ? j : -j);
        if (row_energy > ACC_HI) row_energy = ACC_HI;
        if (row_energy < ACC_LO) row_energy = ACC_LO;
        if (!b.last) return;
        flip = 1'b0;
        if (b.active) begin
            e = row_energy;
            if (b.up == b.down) begin
                tun = jperp_q * TROTTER;
                e += b.up ? -tun : tun;
            end
            e = e * 2 + longint'($signed(b.field));
            if (!b.tspin) e = -e;
            beta = (beta_q == 0) ? 1 : longint'(beta_q);
            // SystemVerilog division truncates toward zero, as required.
            thr = (longint'($signed(b.logr)) * 65536) / (beta * 2);
            flip = e > thr;
        end
        row_energy = 0;
        expected_decisions.push_back('{new_spin: b.tspin ^ flip, flipped: flip});
    endfunction

    // Driver: bursts of beats with random gaps. Valid stays up with a fixed
    // payload until the beat is taken.
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_beat(s_beat);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0 && !sender_hold) begin
                    s_beat  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off on request.
    int stall_mode = 0;
    int long_stall_left = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ising_spin_flip_unit_test: errors");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_decisions.size() == 0) begin
                    $error("result beat with no decision pending");
                    error_count = error_count + 1;
                end else begin
                    decision_t want;
                    want = expected_decisions.pop_front();
                    if (m_new_spin !== want.new_spin) begin
                        $error("new_spin: expected %0b, got %0b", want.new_spin, m_new_spin);
                        error_count = error_count + 1;
                    end
                    if (m_flipped !== want.flipped) begin
                        $error("flipped: expected %0b, got %0b", want.flipped, m_flipped);
                        error_count = error_count + 1;
                    end
                end
            end
            if (long_stall_req && long_stall_left == 0) begin
                long_stall_left <= 400;
                m_ready <= 1'b0;
            end else if (long_stall_left > 1) begin
                long_stall_left <= long_stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                if (long_stall_left == 1) long_stall_left <= long_stall_left - 1;
                if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_fix();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'(-($urandom_range(0, 65536 * 8)))
                                           : 32'($urandom_range(0, 65536 * 8));
            default: return $urandom;
        endcase
    endfunction

    // Queue one row of random couplings; the last beat carries the decision inputs.
    task automatic push_row(int len, bit act);
        beat_t b;
        for (int i = 0; i < len; i++) begin
            b = '0;
            b.nspin    = $urandom_range(0, 1);
            b.coupling = rand_fix();
            b.last     = (i == len - 1);
            // Apart from active, the side fields are random on every beat; the unit reads them at the end.
            b.active   = act;
            b.tspin    = $urandom_range(0, 1);
            b.up       = $urandom_range(0, 1);
            b.down     = $urandom_range(0, 1);
            b.field    = rand_fix();
            // Log-random is mostly negative and small, now and then anything.
            b.logr     = ($urandom_range(0, 3) == 0) ? rand_fix()
                                                     : 32'(-($urandom_range(0, 65536 * 6)));
            pending_beats.push_back(b);
        end
    endtask

    task automatic push_one(bit ns, logic [31:0] j, bit act, bit ts, bit u, bit d,
                            logic [31:0] h, logic [31:0] lr);
        pending_beats.push_back('{ns, j, 1'b1, act, ts, u, d, h, lr});
    endtask

    // Drain the unit: wait for every decision, then wait out a margin.
    task automatic drain();
        while (pending_beats.size() > 0 || s_valid || expected_decisions.size() > 0)
            @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic write_reg(logic [isfu_pkg::W_ADDR-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == isfu_pkg::REG_BETA) beta_q = val[30:0];
        else if (idx == isfu_pkg::REG_JPERP) jperp_q = longint'($signed(val));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    logic [31:0] betas[5]  = '{32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                               32'h0000_0000, 32'h0000_8000};
    logic [31:0] jperps[5] = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'hFFFF_0000, 32'h0003_0000};

    initial begin
        beta_q = 31'd65536;
        jperp_q = 0;
        row_energy = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows: extremes of every field, inactive rows, both tunnel
        // signs, a one-beat row and a long row of extreme couplings.
        push_one(1, 32'h7FFF_FFFF, 1, 1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        push_one(0, 32'h8000_0000, 1, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_one(1, 32'h0001_0000, 0, 1, 1, 1, 32'h0, 32'h0);
        push_one(0, 32'h0001_0000, 0, 0, 0, 1, 32'h0, 32'h0);
        push_one(1, 32'h0, 1, 1, 0, 1, 32'h0, 32'h0);
        push_one(0, 32'h0, 1, 0, 1, 0, 32'h0, 32'hFFFF_0000);
        push_one(1, 32'hFFFF_FFFF, 1, 1, 1, 0, 32'h1, 32'h1);
        push_row(5, 1);
        push_row(3, 0);
        drain();
        write_reg(isfu_pkg::REG_JPERP, 32'h7FFF_FFFF);
        write_reg(isfu_pkg::REG_BETA, 32'h0000_0000);
        write_reg(2'd3, 32'h1234_5678);   // unused index, must be ignored
        for (int i = 0; i < 4; i++) push_one(i[0], 32'h0, 1, i[1], i[0], i[1], 32'h0, 32'h0);
        // A row of 40 extreme couplings of one sign drives the sum far from zero.
        for (int i = 0; i < 39; i++)
            pending_beats.push_back('{1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      32'h0, 32'h0});
        push_one(1, 32'h7FFF_FFFF, 1, 0, 1, 0, 32'h0, 32'h0);
        drain();

        // Random phases, one per register setting.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(isfu_pkg::REG_BETA, betas[ph]);
            write_reg(isfu_pkg::REG_JPERP, jperps[ph]);
            for (int r = 0; r < N_RAND_ROWS / 5; r++)
                push_row(($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 5),
                         $urandom_range(0, 4) != 0);
            if (ph == 1) begin
                // Hold the receiver off while the sender keeps offering beats.
                long_stall_req = 1'b1;
                @(posedge aclk);
                @(posedge aclk);
                long_stall_req = 1'b0;
            end
            if (ph == 3) begin
                // Sender pauses until every outstanding decision has come back.
                sender_hold = 1'b1;
                while (expected_decisions.size() > 0) @(posedge aclk);
                sender_hold = 1'b0;
            end
            drain();
        end

        if (error_count == 0) begin
            $display("ising_spin_flip_unit_test: clean");
        end else begin
            $display("ising_spin_flip_unit_test: errors");
        end
        $finish;
    end

endmodule
